/* rtl/assert_macros.svh */
// assertion macros shared by the rtl files that check themselves
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent checked in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/knt4_pkg.sv */
// shared constants and controller/datapath interface types for the base-4 keith test
// no dependencies
package knt4_pkg;

  // operand and digit geometry
  localparam int NUMBER_BITS = 56;
  localparam int DIGIT_BITS  = 2;
  localparam int MAX_DIGITS  = NUMBER_BITS / DIGIT_BITS;
  // running sum stays below twice the number under test
  localparam int SUM_BITS    = NUMBER_BITS + 1;
  localparam int ADDR_BITS   = $clog2(MAX_DIGITS);
  localparam int CNT_BITS    = $clog2(MAX_DIGITS + 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;  // capture the number, clear sum and pointers
    logic scan;   // drop one leading zero digit
    logic load;   // seed one window entry with the top digit
    logic gen;    // generate one term
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic few_digits; // incoming number has fewer than two digits
    logic top_nz;     // top digit of the shift register is non-zero
    logic load_last;  // this load writes the last seed digit
    logic reached;    // running sum has reached or passed the number
    logic hit;        // running sum equals the number
  } status_t;

endpackage

/* rtl/knt4_ram.sv */
// generic single write port ram with registered read
// no dependencies
module knt4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/knt4_dpath.sv */
// datapath: digit shifter, seed loader, term generator and term window
// depends on knt4_pkg and knt4_ram
module knt4_dpath (
  input  logic                               clk,
  input  logic [knt4_pkg::NUMBER_BITS-1:0]   number,
  input  knt4_pkg::cmd_t                     cmd,
  output knt4_pkg::status_t                  status
);

  logic [knt4_pkg::NUMBER_BITS-1:0] shreg;
  logic [knt4_pkg::NUMBER_BITS-1:0] target;
  logic [knt4_pkg::CNT_BITS-1:0]    digits;
  logic [knt4_pkg::ADDR_BITS-1:0]   idx;
  logic [knt4_pkg::ADDR_BITS-1:0]   oldest;
  logic [knt4_pkg::ADDR_BITS-1:0]   oldest_next;
  logic [knt4_pkg::SUM_BITS-1:0]    sum;
  logic [knt4_pkg::SUM_BITS-1:0]    target_ext;
  logic [knt4_pkg::DIGIT_BITS-1:0]  top_digit;
  logic [knt4_pkg::NUMBER_BITS-1:0] shreg_shifted;
  logic [knt4_pkg::SUM_BITS-1:0]    sum_doubled;

  logic                             ram_we;
  logic [knt4_pkg::ADDR_BITS-1:0]   ram_waddr;
  logic [knt4_pkg::NUMBER_BITS-1:0] ram_wdata;
  logic [knt4_pkg::ADDR_BITS-1:0]   ram_raddr;
  logic [knt4_pkg::NUMBER_BITS-1:0] ram_rdata;

  // digit view of the shift register
  assign top_digit     = shreg[knt4_pkg::NUMBER_BITS-1 -: knt4_pkg::DIGIT_BITS];
  assign shreg_shifted = {shreg[knt4_pkg::NUMBER_BITS-knt4_pkg::DIGIT_BITS-1:0],
                          {knt4_pkg::DIGIT_BITS{1'b0}}};

  // circular pointer into the window, wrapping at the digit count
  assign oldest_next = (knt4_pkg::CNT_BITS'(oldest) == digits - knt4_pkg::CNT_BITS'(1))
                       ? '0 : oldest + knt4_pkg::ADDR_BITS'(1);

  assign target_ext  = {1'b0, target};
  assign sum_doubled = {sum[knt4_pkg::SUM_BITS-2:0], 1'b0};

  // status back to the controller
  assign status.few_digits = (number[knt4_pkg::NUMBER_BITS-1:knt4_pkg::DIGIT_BITS] == '0);
  assign status.top_nz     = (top_digit != '0);
  assign status.load_last  = (knt4_pkg::CNT_BITS'(idx) == digits - knt4_pkg::CNT_BITS'(1));
  assign status.reached    = (sum >= target_ext);
  assign status.hit        = (sum == target_ext);

  // window write and prefetch of the oldest term for the next step
  always_comb begin
    ram_we    = cmd.load | cmd.gen;
    ram_waddr = cmd.gen ? oldest : idx;
    ram_wdata = cmd.gen ? sum[knt4_pkg::NUMBER_BITS-1:0]
                        : knt4_pkg::NUMBER_BITS'(top_digit);
    ram_raddr = cmd.gen ? oldest_next : '0;
  end

  // operand, pointer and sum registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      shreg  <= number;
      target <= number;
      digits <= knt4_pkg::CNT_BITS'(knt4_pkg::MAX_DIGITS);
      idx    <= '0;
      oldest <= '0;
      sum    <= '0;
    end else if (cmd.scan) begin
      shreg  <= shreg_shifted;
      digits <= digits - knt4_pkg::CNT_BITS'(1);
    end else if (cmd.load) begin
      shreg  <= shreg_shifted;
      idx    <= idx + knt4_pkg::ADDR_BITS'(1);
      sum    <= sum + knt4_pkg::SUM_BITS'(top_digit);
    end else if (cmd.gen) begin
      // new sum drops the oldest term and adds the new one, which equals the old sum
      sum    <= sum_doubled - knt4_pkg::SUM_BITS'(ram_rdata);
      oldest <= oldest_next;
    end
  end

  knt4_ram #(
    .WIDTH (knt4_pkg::NUMBER_BITS),
    .DEPTH (knt4_pkg::MAX_DIGITS)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/knt4_ctrl.sv */
// controller: sequences scan, seed load and term generation, owns the result register
// depends on knt4_pkg
module knt4_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              number_valid,
  output logic              number_stall,
  output logic              result_valid,
  input  logic              result_stall,
  output logic              is_keith,
  output knt4_pkg::cmd_t    cmd,
  input  knt4_pkg::status_t status
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_GEN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       verdict;
  logic       verdict_next;
  logic       out_free;
  logic       post;

  assign number_stall = (state != S_IDLE);
  assign out_free     = !result_valid || !result_stall;

  // next state and commands
  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    cmd          = '0;
    post         = 1'b0;
    case (state)
      S_IDLE: begin
        if (number_valid) begin
          cmd.start    = 1'b1;
          verdict_next = 1'b0;
          state_next   = status.few_digits ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.top_nz) begin
          state_next = S_LOAD;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_LOAD: begin
        cmd.load = 1'b1;
        if (status.load_last) begin
          state_next = S_GEN;
        end
      end
      S_GEN: begin
        if (status.reached) begin
          verdict_next = status.hit;
          state_next   = S_DONE;
        end else begin
          cmd.gen = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          post       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (post) begin
        result_valid <= 1'b1;
      end else if (out_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  // verdict and result payload
  always_ff @(posedge clk) begin
    verdict <= verdict_next;
    if (post) begin
      is_keith <= verdict;
    end
  end

endmodule

/* rtl/keith_number_test_base4_top.sv */
// channel    | signals                                 | transfer when
// -----------+-----------------------------------------+---------------------
// number in  | number_valid, number_stall, number[55:0] | valid && !stall
// result out | result_valid, result_stall, is_keith     | valid && !stall
//
// one number takes an accept step, a leading-zero scan and seed load over 28 digits
// (one digit each), a step to spot the top digit, one step per generated term, one
// for the final compare and a post step; numbers below 4 go from the accept straight
// to the post; the term loop is paced by the one window read port and one add a cycle
// reset is synchronous and clears the controller state and output valid; the window ram is not cleared
// a result held by result_stall keeps the next number waiting only once posted
// depends on knt4_pkg, knt4_ctrl, knt4_dpath, knt4_ram and assert_macros.svh
`include "assert_macros.svh"

module keith_number_test_base4_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             number_valid,
  output logic                             number_stall,
  input  logic [knt4_pkg::NUMBER_BITS-1:0] number,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic                             is_keith
);

  knt4_pkg::cmd_t    cmd;
  knt4_pkg::status_t status;

  // sequencer
  knt4_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .number_valid (number_valid),
    .number_stall (number_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_keith     (is_keith),
    .cmd          (cmd),
    .status       (status)
  );

  // digit handling and term generation
  knt4_dpath u_dpath (
    .clk    (clk),
    .number (number),
    .cmd    (cmd),
    .status (status)
  );

  // commands are mutually exclusive
  `ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.start, cmd.scan, cmd.load, cmd.gen}))
  // a number transfer makes the block busy in the next cycle
  `ASSERT_NEXT(a_busy_after_take, number_valid && !number_stall, number_stall)
  // a new result is posted only from a busy cycle
  `ASSERT_SAME(a_post_from_busy, $rose(result_valid), $past(number_stall))

endmodule
